>>> rtl/core/lcl_pkg.sv
// ----------------------------------------------------------------------------
// lcl_pkg
// Shared types and constants for the LFU store with LRU tie-break.
// ----------------------------------------------------------------------------
package lcl_pkg;

   // fixed field widths
   localparam int KEY_W     = 32;
   localparam int DATA_W    = 32;
   localparam int CAP_W     = 5;
   localparam int STAMP_W   = 48;

   // capacity register value after reset
   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   // result value of a miss or a put
   localparam logic [DATA_W-1:0] NO_VALUE = '1;

   // request operations
   typedef enum logic {
      CMD_GET = 1'b0,
      CMD_PUT = 1'b1
   } op_type;

   // controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_WRITE,
      ST_DONE
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic start;     // capture request, restart scan
      logic scan_en;   // walk the entry memories
      logic write_en;  // commit the update of this request
      logic load_rsp;  // move the result into the output register
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic scan_done; // last entry compared
      logic rsp_free;  // output register can take a result
   } dp_status_type;

endpackage

>>> rtl/core/lcl_req_if.sv
// ----------------------------------------------------------------------------
// lcl_req_if
// Request channel: get or put of one key.
// ----------------------------------------------------------------------------
interface lcl_req_if;
   import lcl_pkg::*;

   logic                      valid;
   logic                      ready;
   logic                      cmd;
   logic signed [KEY_W-1:0]   key;
   logic signed [DATA_W-1:0]  value;

   modport source (output valid, output cmd, output key, output value, input ready);
   modport sink   (input valid, input cmd, input key, input value, output ready);
endinterface

>>> rtl/core/lcl_rsp_if.sv
// ----------------------------------------------------------------------------
// lcl_rsp_if
// Response channel: one result per request.
// ----------------------------------------------------------------------------
interface lcl_rsp_if;
   import lcl_pkg::*;

   logic                      valid;
   logic                      ready;
   logic                      hit;
   logic signed [DATA_W-1:0]  read_value;
   logic                      evicted;
   logic signed [KEY_W-1:0]   evicted_key;

   modport source (output valid, output hit, output read_value, output evicted,
                   output evicted_key, input ready);
   modport sink   (input valid, input hit, input read_value, input evicted,
                   input evicted_key, output ready);
endinterface

>>> rtl/core/lcl_csr_if.sv
// ----------------------------------------------------------------------------
// lcl_csr_if
// Configuration write channel for the capacity register.
// ----------------------------------------------------------------------------
interface lcl_csr_if;
   import lcl_pkg::*;

   logic              valid;
   logic              ready;
   logic [CAP_W-1:0]  data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/core/lcl_ctrl.sv
// ----------------------------------------------------------------------------
// lcl_ctrl
// Request sequencer: accept, scan, commit, hand off the result.
// ----------------------------------------------------------------------------
module lcl_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  lcl_pkg::dp_status_type status,
   output lcl_pkg::ctrl_cmd_type  cmd
);
   import lcl_pkg::*;

   state_type state_ff;
   state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_ready    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan_en = 1'b1;
            if (status.scan_done) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            cmd.write_en = 1'b1;
            state_in     = ST_DONE;
         end
         ST_DONE: begin
            // wait until an earlier result has left the output register
            if (status.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

>>> rtl/core/lcl_datapath.sv
// ----------------------------------------------------------------------------
// lcl_datapath
// Entry memories, scan compare, update logic and output register.
// ----------------------------------------------------------------------------
module lcl_datapath #(
   parameter int CAPACITY   = 16,
   parameter int COUNT_BITS = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  lcl_pkg::ctrl_cmd_type            cmd,
   output lcl_pkg::dp_status_type           status,
   // request payload
   input  logic                             req_cmd,
   input  logic signed [lcl_pkg::KEY_W-1:0] req_key,
   input  logic signed [lcl_pkg::DATA_W-1:0] req_value,
   // capacity write
   input  logic                             csr_write,
   input  logic [lcl_pkg::CAP_W-1:0]        csr_data,
   // result
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_hit,
   output logic signed [lcl_pkg::DATA_W-1:0] rsp_read_value,
   output logic                             rsp_evicted,
   output logic signed [lcl_pkg::KEY_W-1:0] rsp_evicted_key
);
   import lcl_pkg::*;

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int EFF_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
   localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(CAPACITY);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);
   localparam logic [EFF_W-1:0] CAP_LIMIT = EFF_W'(CAPACITY);

   // entry memories and valid bits
   logic [KEY_W-1:0]      key_mem   [CAPACITY];
   logic [DATA_W-1:0]     data_mem  [CAPACITY];
   logic [COUNT_BITS-1:0] uses_mem  [CAPACITY];
   logic [STAMP_W-1:0]    stamp_mem [CAPACITY];
   logic [CAPACITY-1:0]   valid_ff;

   logic [CAP_W-1:0]      capacity_ff;
   logic [STAMP_W-1:0]    clock_ff;

   // captured request
   logic                  op_ff;
   logic [KEY_W-1:0]      key_ff;
   logic [DATA_W-1:0]     value_ff;

   // scan pipeline
   logic [CNT_W-1:0]      rd_cnt_ff;
   logic                  cmp_vld_ff;
   logic [IDX_W-1:0]      cmp_idx_ff;
   logic [KEY_W-1:0]      rd_key_ff;
   logic [DATA_W-1:0]     rd_data_ff;
   logic [COUNT_BITS-1:0] rd_uses_ff;
   logic [STAMP_W-1:0]    rd_stamp_ff;
   logic                  rd_issue;

   // scan results
   logic                  hit_found_ff;
   logic [IDX_W-1:0]      hit_idx_ff;
   logic [DATA_W-1:0]     hit_data_ff;
   logic [COUNT_BITS-1:0] hit_uses_ff;
   logic                  vic_found_ff;
   logic [IDX_W-1:0]      vic_idx_ff;
   logic [KEY_W-1:0]      vic_key_ff;
   logic [COUNT_BITS-1:0] vic_uses_ff;
   logic [STAMP_W-1:0]    vic_stamp_ff;
   logic                  free_found_ff;
   logic [IDX_W-1:0]      free_idx_ff;
   logic [CNT_W-1:0]      used_ff;

   // output register
   logic                  rsp_valid_ff;
   logic                  rsp_hit_ff;
   logic [DATA_W-1:0]     rsp_value_ff;
   logic                  rsp_evicted_ff;
   logic [KEY_W-1:0]      rsp_evkey_ff;

   // decision terms
   logic                  is_put;
   logic                  cap_zero;
   logic                  do_bump;
   logic                  do_insert;
   logic                  do_evict;
   logic                  mem_wr;
   logic [IDX_W-1:0]      wr_idx;
   logic [DATA_W-1:0]     wr_data;
   logic [COUNT_BITS-1:0] wr_uses;
   logic                  cur_valid;
   logic                  older;
   logic [CAPACITY-1:0]   valid_in;

   // capacity register
   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAP_RESET;
      end else if (csr_write) begin
         capacity_ff <= csr_data;
      end
   end

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         op_ff    <= req_cmd;
         key_ff   <= req_key;
         value_ff <= req_value;
      end
   end

   // read address counter, one entry per cycle
   assign rd_issue = cmd.scan_en && (rd_cnt_ff != LAST_CNT);

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_cnt_ff  <= '0;
         cmp_vld_ff <= 1'b0;
      end else begin
         cmp_vld_ff <= rd_issue;
         if (cmd.start) begin
            rd_cnt_ff <= '0;
         end else if (rd_issue) begin
            rd_cnt_ff <= rd_cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmp_idx_ff <= rd_cnt_ff[IDX_W-1:0];
   end

   // entry memories: one write or one read per cycle
   always_ff @(posedge clock) begin
      if (mem_wr) begin
         key_mem[wr_idx]   <= key_ff;
         data_mem[wr_idx]  <= wr_data;
         uses_mem[wr_idx]  <= wr_uses;
         stamp_mem[wr_idx] <= clock_ff;
      end
      rd_key_ff   <= key_mem[rd_cnt_ff[IDX_W-1:0]];
      rd_data_ff  <= data_mem[rd_cnt_ff[IDX_W-1:0]];
      rd_uses_ff  <= uses_mem[rd_cnt_ff[IDX_W-1:0]];
      rd_stamp_ff <= stamp_mem[rd_cnt_ff[IDX_W-1:0]];
   end

   // compare one entry against the key and the running victim
   assign cur_valid = valid_ff[cmp_idx_ff];
   assign older     = !vic_found_ff || (rd_uses_ff < vic_uses_ff) ||
                      ((rd_uses_ff == vic_uses_ff) && (rd_stamp_ff < vic_stamp_ff));

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         hit_found_ff  <= 1'b0;
         vic_found_ff  <= 1'b0;
         free_found_ff <= 1'b0;
         used_ff       <= '0;
      end else if (cmp_vld_ff) begin
         if (cur_valid) begin
            used_ff <= used_ff + 1'b1;
         end
         if (cur_valid && !hit_found_ff && (rd_key_ff == key_ff)) begin
            hit_found_ff <= 1'b1;
            hit_idx_ff   <= cmp_idx_ff;
            hit_data_ff  <= rd_data_ff;
            hit_uses_ff  <= rd_uses_ff;
         end
         if (cur_valid && older) begin
            vic_found_ff <= 1'b1;
            vic_idx_ff   <= cmp_idx_ff;
            vic_key_ff   <= rd_key_ff;
            vic_uses_ff  <= rd_uses_ff;
            vic_stamp_ff <= rd_stamp_ff;
         end
         if (!cur_valid && !free_found_ff) begin
            free_found_ff <= 1'b1;
            free_idx_ff   <= cmp_idx_ff;
         end
      end
   end

   assign status.scan_done = cmp_vld_ff && (cmp_idx_ff == LAST_IDX);
   assign status.rsp_free  = !rsp_valid_ff || rsp_ready;

   // what this request changes; a get ignores the capacity
   assign is_put    = (op_type'(op_ff) == CMD_PUT);
   assign cap_zero  = (capacity_ff == '0);
   assign do_bump   = hit_found_ff && (!is_put || !cap_zero);
   assign do_insert = is_put && !cap_zero && !hit_found_ff;
   assign do_evict  = do_insert &&
                      (EFF_W'(used_ff) >= ((EFF_W'(capacity_ff) > CAP_LIMIT) ?
                                           CAP_LIMIT : EFF_W'(capacity_ff)));
   assign mem_wr    = cmd.write_en && (do_bump || do_insert);

   // insert goes to the lowest free slot, the victim's slot included
   always_comb begin
      if (do_bump) begin
         wr_idx = hit_idx_ff;
      end else if (do_evict) begin
         wr_idx = (free_found_ff && (free_idx_ff < vic_idx_ff)) ? free_idx_ff : vic_idx_ff;
      end else begin
         wr_idx = free_idx_ff;
      end
   end

   assign wr_data = is_put ? value_ff : hit_data_ff;
   // saturating use count
   assign wr_uses = !do_bump ? COUNT_BITS'(1) :
                    (&hit_uses_ff) ? hit_uses_ff : hit_uses_ff + 1'b1;

   // next valid bits: drop the victim, then mark the written slot
   always_comb begin
      valid_in = valid_ff;
      if (do_evict) begin
         valid_in[vic_idx_ff] = 1'b0;
      end
      valid_in[wr_idx] = 1'b1;
   end

   // valid bits and touch clock
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         clock_ff <= '0;
      end else if (mem_wr) begin
         valid_ff <= valid_in;
         clock_ff <= clock_ff + 1'b1;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_hit_ff     <= do_bump;
         rsp_value_ff   <= (!is_put && hit_found_ff) ? hit_data_ff : NO_VALUE;
         rsp_evicted_ff <= do_evict;
         rsp_evkey_ff   <= do_evict ? vic_key_ff : '0;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_read_value  = rsp_value_ff;
   assign rsp_evicted     = rsp_evicted_ff;
   assign rsp_evicted_key = rsp_evkey_ff;

endmodule

>>> rtl/core/lfu_cache_lru_tiebreak_top.sv
// ----------------------------------------------------------------------------
// lfu_cache_lru_tiebreak_top
// Fully associative key/value store with LFU replacement, LRU tie-break.
// ----------------------------------------------------------------------------
// Each get or put request walks all CAPACITY entries, one per cycle, through
// single-port entry memories, matching the key and tracking the victim (lowest
// use count, oldest stamp) in the same pass; the update is committed after the
// scan. The result waits in an output register, so the next request is taken
// while it is still pending; a new result waits until the last one is taken.
// Use counts saturate at 2^COUNT_BITS - 1; the capacity register limits
// occupancy and a capacity of zero turns puts into no-ops. The entry memories
// are not cleared at reset; the valid bits, touch clock, capacity and control
// registers are, so the block is ready as soon as reset is released.
// ----------------------------------------------------------------------------
module lfu_cache_lru_tiebreak_top #(
   parameter int CAPACITY   = 16,
   parameter int COUNT_BITS = 16
) (
   input  logic      clock,
   input  logic      reset,
   lcl_req_if.sink   req_chan,
   lcl_rsp_if.source rsp_chan,
   lcl_csr_if.sink   csr_chan
);
   import lcl_pkg::*;

   ctrl_cmd_type  ctrl_cmd;
   dp_status_type dp_status;

   // capacity is to be written only while idle; the block does not enforce it, so the port is always open
   assign csr_chan.ready = 1'b1;

   // sequencer
   lcl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (dp_status),
      .cmd       (ctrl_cmd)
   );

   // storage and compare
   lcl_datapath #(
      .CAPACITY   (CAPACITY),
      .COUNT_BITS (COUNT_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (ctrl_cmd),
      .status          (dp_status),
      .req_cmd         (req_chan.cmd),
      .req_key         (req_chan.key),
      .req_value       (req_chan.value),
      .csr_write       (csr_chan.valid),
      .csr_data        (csr_chan.data),
      .rsp_valid       (rsp_chan.valid),
      .rsp_ready       (rsp_chan.ready),
      .rsp_hit         (rsp_chan.hit),
      .rsp_read_value  (rsp_chan.read_value),
      .rsp_evicted     (rsp_chan.evicted),
      .rsp_evicted_key (rsp_chan.evicted_key)
   );

`ifndef SYNTHESIS
   // busy right after taking a request
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("request accepted while a scan was starting");

   // a pending result is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      ctrl_cmd.load_rsp |-> dp_status.rsp_free)
      else $error("result loaded over a pending response");

   // no result right after acceptance, the scan comes first
   a_scan_first: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !ctrl_cmd.load_rsp && !ctrl_cmd.write_en)
      else $error("commit without a scan");
`endif

endmodule
